### sv/sskc_pkg.sv
// ----------------------------------------------------------------------------
// Stereo soft-knee compressor package
// Shared constants, datapath command codes and table builder functions.
// ----------------------------------------------------------------------------
package sskc_pkg;

  localparam int DEF_SAMPLE_BITS = 24;
  localparam int DEF_LOG_ENTRIES = 64;
  localparam int DEF_EXP_ENTRIES = 64;

  localparam int NORM_W     = 32;
  localparam int ENV_W      = 25;
  localparam int MA_W       = 33;
  localparam int MB_W       = 25;
  localparam int P_W        = MA_W + MB_W + 1;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [2:0] NRM_TOP = 3'($clog2(NORM_W) - 1);

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOPE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KNEE_W    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KNEE_C    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAKEUP    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ATTACK    = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 3'd6;

  localparam logic [15:0] RST_THRESHOLD = 16'hEC00;
  localparam logic [15:0] RST_SLOPE     = 16'd32768;
  localparam logic [13:0] RST_KNEE_W    = 14'd0;
  localparam logic [15:0] RST_KNEE_C    = 16'd0;
  localparam logic [15:0] RST_MAKEUP    = 16'd4096;
  localparam logic [23:0] RST_ATTACK    = 24'd34915;
  localparam logic [23:0] RST_RELEASE   = 24'd3495;

  localparam logic signed [ENV_W-1:0] FLOOR_DB = -25'sd6291456;
  localparam logic [MB_W-1:0] DB_PER_OCT = 25'd394566;
  localparam logic [MB_W-1:0] OCT_PER_DB = 25'd10885;
  localparam int PEAK_FLOOR = 8;
  localparam logic [19:0] R8_MAX = 20'd32768;

  typedef enum logic [4:0] {
    OP_NONE, OP_CAPTURE, OP_ABS, OP_NORM, OP_LIDX, OP_LTAB, OP_LDB, OP_LVL,
    OP_ENVM, OP_ENVU, OP_OVER, OP_KSQ, OP_KCV, OP_RED, OP_NMUL, OP_EIDX,
    OP_ETAB, OP_GMUL, OP_GT, OP_MULL, OP_MULR, OP_EMIT
  } op_t;

  typedef struct packed {
    op_t        op;
    logic [2:0] nrm_lvl;
  } cmd_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = '0;
    for (int k = 31; k >= 0; k--) begin
      b = 64'(1) << k;
      if (((r | b) * (r | b)) <= v) r = r | b;
    end
    return r;
  endfunction

  function automatic logic [15:0] log_entry(input logic [29:0] frac);
    logic [63:0] m;
    logic [15:0] y;
    m = 64'(frac) + (64'(1) << 30);
    y = '0;
    for (int b = 15; b >= 0; b--) begin
      m = (m * m) >> 30;
      if (m >= (64'(1) << 31)) begin
        m = m >> 1;
        y[b] = 1'b1;
      end
    end
    return y;
  endfunction

  function automatic logic [30:0] exp_entry(input logic [15:0] xq);
    logic [63:0] root [17];
    logic [63:0] y;
    root[0] = 64'(1) << 31;
    for (int k = 1; k <= 16; k++) root[k] = isqrt64(root[k-1] << 32);
    y = 64'(1) << 30;
    for (int k = 1; k <= 16; k++) begin
      if (xq[16-k]) y = (y * root[k]) >> 32;
    end
    return 31'(y);
  endfunction

endpackage

### sv/sskc_ctrl.sv
// ----------------------------------------------------------------------------
// Stereo soft-knee compressor controller
// Steps the datapath through one frame and owns the request handshakes.
// ----------------------------------------------------------------------------
module sskc_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  logic            out_ready,
  output sskc_pkg::cmd_t  cmd
);
  import sskc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ABS, S_NORM, S_LIDX, S_LTAB, S_LDB, S_LVL, S_ENVM, S_ENVU,
    S_OVER, S_KSQ, S_KCV, S_RED, S_NMUL, S_EIDX, S_ETAB, S_GMUL, S_GT,
    S_MULL, S_MULR, S_DONE
  } state_t;

  state_t     state_r, state_nxt;
  logic [2:0] nrm_r, nrm_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    nrm_nxt       = nrm_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = OP_NONE;
    cmd.nrm_lvl   = nrm_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.op    = OP_CAPTURE;
          state_nxt = S_ABS;
        end
      end
      S_ABS: begin
        cmd.op    = OP_ABS;
        nrm_nxt   = NRM_TOP;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.op = OP_NORM;
        if (nrm_r == 3'd0) begin
          state_nxt = S_LIDX;
        end else begin
          nrm_nxt = nrm_r - 3'd1;
        end
      end
      S_LIDX: begin cmd.op = OP_LIDX; state_nxt = S_LTAB; end
      S_LTAB: begin cmd.op = OP_LTAB; state_nxt = S_LDB;  end
      S_LDB:  begin cmd.op = OP_LDB;  state_nxt = S_LVL;  end
      S_LVL:  begin cmd.op = OP_LVL;  state_nxt = S_ENVM; end
      S_ENVM: begin cmd.op = OP_ENVM; state_nxt = S_ENVU; end
      S_ENVU: begin cmd.op = OP_ENVU; state_nxt = S_OVER; end
      S_OVER: begin cmd.op = OP_OVER; state_nxt = S_KSQ;  end
      S_KSQ:  begin cmd.op = OP_KSQ;  state_nxt = S_KCV;  end
      S_KCV:  begin cmd.op = OP_KCV;  state_nxt = S_RED;  end
      S_RED:  begin cmd.op = OP_RED;  state_nxt = S_NMUL; end
      S_NMUL: begin cmd.op = OP_NMUL; state_nxt = S_EIDX; end
      S_EIDX: begin cmd.op = OP_EIDX; state_nxt = S_ETAB; end
      S_ETAB: begin cmd.op = OP_ETAB; state_nxt = S_GMUL; end
      S_GMUL: begin cmd.op = OP_GMUL; state_nxt = S_GT;   end
      S_GT:   begin cmd.op = OP_GT;   state_nxt = S_MULL; end
      S_MULL: begin cmd.op = OP_MULL; state_nxt = S_MULR; end
      S_MULR: begin cmd.op = OP_MULR; state_nxt = S_DONE; end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      nrm_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      nrm_r       <= nrm_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/sskc_dp.sv
// ----------------------------------------------------------------------------
// Stereo soft-knee compressor datapath
// Registers, lookup tables and one shared multiplier driven by the controller.
// ----------------------------------------------------------------------------
module sskc_dp #(
  parameter int SAMPLE_BITS       = sskc_pkg::DEF_SAMPLE_BITS,
  parameter int LOG_TABLE_ENTRIES = sskc_pkg::DEF_LOG_ENTRIES,
  parameter int EXP_TABLE_ENTRIES = sskc_pkg::DEF_EXP_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  sskc_pkg::cmd_t                    cmd,
  input  logic                              cfg_wr_en,
  input  logic [sskc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sskc_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_sample,
  output logic signed [SAMPLE_BITS-1:0]     out_left_out,
  output logic signed [SAMPLE_BITS-1:0]     out_right_out,
  output logic                              out_clipped,
  output logic signed [15:0]                out_gain_reduction
);
  import sskc_pkg::*;

  localparam int SB     = SAMPLE_BITS;
  localparam int LOG_IW = $clog2(LOG_TABLE_ENTRIES);
  localparam int EXP_IW = $clog2(EXP_TABLE_ENTRIES);
  localparam logic signed [22:0] L2_BIAS = 23'((SAMPLE_BITS - 1) * 65536);
  localparam logic signed [P_W-1:0] SAT_HI = P_W'((longint'(1) << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [P_W-1:0] SAT_LO = -SAT_HI - 1;

  logic [15:0] log_rom [LOG_TABLE_ENTRIES];
  logic [30:0] exp_rom [EXP_TABLE_ENTRIES];

  for (genvar gi = 0; gi < LOG_TABLE_ENTRIES; gi++) begin : g_log
    localparam logic [29:0] LF = 30'((longint'(gi) << 30) / LOG_TABLE_ENTRIES);
    assign log_rom[gi] = log_entry(LF);
  end

  for (genvar gj = 0; gj < EXP_TABLE_ENTRIES; gj++) begin : g_exp
    localparam logic [15:0] XQ = 16'((longint'(gj) << 16) / EXP_TABLE_ENTRIES);
    assign exp_rom[gj] = exp_entry(XQ);
  end

  logic signed [15:0]       thr_r;
  logic [15:0]              slope_r, curve_r, mk_r;
  logic [13:0]              kw_r;
  logic [23:0]              att_r, rel_r;
  logic signed [ENV_W-1:0]  env_r, env_nxt;

  logic signed [SB-1:0]     s_l_r, s_r_r, res_l_r;
  logic                     clip_l_r;
  logic [NORM_W-1:0]        norm_r;
  logic [4:0]               msb_r;
  logic                     floor_r;
  logic [21:0]              mag_r;
  logic signed [ENV_W-1:0]  lvl_r;
  logic signed [ENV_W:0]    over_r;
  logic                     knee_r;
  logic [21:0]              x_r;
  logic [27:0]              red_r;
  logic [20:0]              n_r;
  logic [30:0]              g_r;
  logic [19:0]              gt_r;
  logic signed [P_W-1:0]    prod_r;

  logic signed [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]          mul_b;
  logic                     mul_en;

  logic [SB-1:0]            abs_l, abs_r, peak;
  logic [5:0]               nsh;
  logic                     top_zero;
  logic [10:0]              lidx_raw, eidx_raw;
  logic [LOG_IW-1:0]        lidx;
  logic [EXP_IW-1:0]        eidx;
  logic signed [22:0]       l2;
  logic signed [ENV_W:0]    diff, over, half_s;
  logic [4:0]               ip;
  logic [19:0]              r8_raw;
  logic [15:0]              r8;
  logic [SB:0]              sat_r_res;

  function automatic logic [SB:0] sat(input logic signed [P_W-1:0] p);
    logic signed [P_W-1:0] v;
    v = p >>> 16;
    if (v > SAT_HI) return {1'b1, SAT_HI[SB-1:0]};
    if (v < SAT_LO) return {1'b1, SAT_LO[SB-1:0]};
    return {1'b0, v[SB-1:0]};
  endfunction

  always_comb begin
    abs_l    = s_l_r[SB-1] ? SB'(-s_l_r) : SB'(s_l_r);
    abs_r    = s_r_r[SB-1] ? SB'(-s_r_r) : SB'(s_r_r);
    peak     = (abs_l > abs_r) ? abs_l : abs_r;
    nsh      = 6'(1) << cmd.nrm_lvl;
    top_zero = ((norm_r >> (NORM_W - int'(nsh))) == '0);

    lidx_raw = prod_r[40:30];
    lidx     = (lidx_raw >= 11'(LOG_TABLE_ENTRIES)) ? LOG_IW'(LOG_TABLE_ENTRIES - 1)
                                                     : lidx_raw[LOG_IW-1:0];
    l2       = $signed({2'b00, msb_r, log_rom[lidx]}) - L2_BIAS;

    diff     = (ENV_W+1)'(lvl_r) - (ENV_W+1)'(env_r);
    env_nxt  = env_r + ENV_W'(prod_r >>> 24);

    over     = (ENV_W+1)'(env_r) - (ENV_W+1)'($signed({thr_r, 8'h00}));
    half_s   = $signed((ENV_W+1)'({kw_r, 7'b0}));

    r8_raw   = red_r[27:8];
    r8       = (r8_raw > R8_MAX) ? 16'(R8_MAX) : r8_raw[15:0];

    ip       = n_r[20:16];
    eidx_raw = prod_r[26:16];
    eidx     = (eidx_raw >= 11'(EXP_TABLE_ENTRIES)) ? EXP_IW'(EXP_TABLE_ENTRIES - 1)
                                                     : eidx_raw[EXP_IW-1:0];
    sat_r_res = sat(prod_r);
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd.op)
      OP_LIDX: begin mul_a = MA_W'(norm_r[30:1]); mul_b = MB_W'(LOG_TABLE_ENTRIES); end
      OP_LDB:  begin mul_a = MA_W'(mag_r);        mul_b = DB_PER_OCT; end
      OP_ENVM: begin
        mul_a = MA_W'(diff);
        mul_b = (lvl_r > env_r) ? MB_W'(att_r) : MB_W'(rel_r);
      end
      OP_KSQ: begin
        mul_a = knee_r ? MA_W'(x_r) : MA_W'(over_r);
        mul_b = knee_r ? MB_W'(x_r) : MB_W'(slope_r);
      end
      OP_KCV:  begin mul_a = MA_W'(prod_r[43:16]); mul_b = MB_W'(curve_r); end
      OP_NMUL: begin mul_a = MA_W'(r8);            mul_b = OCT_PER_DB; end
      OP_EIDX: begin mul_a = MA_W'(prod_r[23:8]);  mul_b = MB_W'(EXP_TABLE_ENTRIES); end
      OP_GMUL: begin mul_a = MA_W'(g_r);           mul_b = MB_W'(mk_r); end
      OP_MULL: begin mul_a = MA_W'(s_l_r);         mul_b = MB_W'(gt_r); end
      OP_MULR: begin mul_a = MA_W'(s_r_r);         mul_b = MB_W'(gt_r); end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r   <= RST_THRESHOLD;
      slope_r <= RST_SLOPE;
      kw_r    <= RST_KNEE_W;
      curve_r <= RST_KNEE_C;
      mk_r    <= RST_MAKEUP;
      att_r   <= RST_ATTACK;
      rel_r   <= RST_RELEASE;
      env_r   <= FLOOR_DB;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_THRESHOLD: thr_r   <= cfg_data[15:0];
          CFG_SLOPE:     slope_r <= cfg_data[15:0];
          CFG_KNEE_W:    kw_r    <= cfg_data[13:0];
          CFG_KNEE_C:    curve_r <= cfg_data[15:0];
          CFG_MAKEUP:    mk_r    <= cfg_data[15:0];
          CFG_ATTACK:    att_r   <= cfg_data;
          CFG_RELEASE:   rel_r   <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == OP_ENVU) env_r <= env_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_en) prod_r <= mul_a * $signed({1'b0, mul_b});
    case (cmd.op)
      OP_CAPTURE: begin
        s_l_r <= in_left_sample;
        s_r_r <= in_right_sample;
      end
      OP_ABS: begin
        norm_r  <= NORM_W'(peak);
        msb_r   <= 5'(NORM_W - 1);
        floor_r <= (peak <= SB'(PEAK_FLOOR));
      end
      OP_NORM: begin
        if (top_zero) begin
          norm_r <= norm_r << nsh;
          msb_r  <= msb_r - nsh[4:0];
        end
      end
      OP_LTAB: mag_r <= (l2 >= 0) ? '0 : 22'(-l2);
      OP_LVL:  lvl_r <= floor_r ? FLOOR_DB : -$signed({1'b0, prod_r[39:16]});
      OP_OVER: begin
        over_r <= over;
        knee_r <= (kw_r != '0) && (over > -half_s) && (over < half_s);
        x_r    <= 22'(over + half_s);
      end
      OP_KCV:  red_r <= (!knee_r && over_r > 0) ? 28'(prod_r[39:16]) : '0;
      OP_RED:  if (knee_r) red_r <= prod_r[43:16];
      OP_EIDX: n_r <= prod_r[28:8];
      OP_ETAB: g_r <= (ip < 5'd31) ? (exp_rom[eidx] >> ip) : '0;
      OP_GT:   gt_r <= prod_r[45:26];
      OP_MULR: {clip_l_r, res_l_r} <= sat(prod_r);
      OP_EMIT: begin
        out_left_out       <= res_l_r;
        out_right_out      <= sat_r_res[SB-1:0];
        out_clipped        <= clip_l_r | sat_r_res[SB];
        out_gain_reduction <= 16'(-$signed({1'b0, r8}));
      end
      default: ;
    endcase
  end

endmodule

### sv/stereo_soft_knee_compressor_core.sv
// ----------------------------------------------------------------------------
// Stereo soft-knee compressor core
// A new frame is accepted only in idle, once the previous frame has reached the output
// registers, as the controller steps every frame through the single shared multiplier.
// Reset (synchronous, rst_n low) restores register defaults and the -96 dB envelope.
// ----------------------------------------------------------------------------
module stereo_soft_knee_compressor_core #(
  parameter int SAMPLE_BITS       = sskc_pkg::DEF_SAMPLE_BITS,
  parameter int LOG_TABLE_ENTRIES = sskc_pkg::DEF_LOG_ENTRIES,
  parameter int EXP_TABLE_ENTRIES = sskc_pkg::DEF_EXP_ENTRIES
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_sample,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_sample,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [SAMPLE_BITS-1:0]     out_left_out,
  output logic signed [SAMPLE_BITS-1:0]     out_right_out,
  output logic                              out_clipped,
  output logic signed [15:0]                out_gain_reduction,
  input  logic                              cfg_wr_en,
  input  logic [sskc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sskc_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sskc_pkg::*;

  cmd_t cmd;

  sskc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sskc_dp #(
    .SAMPLE_BITS       (SAMPLE_BITS),
    .LOG_TABLE_ENTRIES (LOG_TABLE_ENTRIES),
    .EXP_TABLE_ENTRIES (EXP_TABLE_ENTRIES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_left_sample     (in_left_sample),
    .in_right_sample    (in_right_sample),
    .out_left_out       (out_left_out),
    .out_right_out      (out_right_out),
    .out_clipped        (out_clipped),
    .out_gain_reduction (out_gain_reduction)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("frame accepted while previous frame in progress");

  a_emit_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_EMIT) |-> (!out_valid || out_ready))
    else $error("result overwritten before it was taken");

  a_reduction_sign: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain_reduction[15] || out_gain_reduction == '0))
    else $error("positive gain reduction");
`endif

endmodule
